// ----- rtl/core/lrl_pkg.sv -----
// Shared types and constants for the Luby restart limit block.
package lrl_pkg;

   localparam int INDEX_BITS_DEF = 30;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int EXP_BITS       = 5;
   localparam int CFG_BITS       = 16;
   localparam int LIMIT_BITS     = 64;
   localparam int HALF_BITS      = 32;
   localparam int PROD_BITS      = HALF_BITS + CFG_BITS;
   localparam int ACC_BITS       = LIMIT_BITS + CFG_BITS;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RESTART_BASE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GROWTH_FACTOR = 2'd1;

   localparam logic [CFG_BITS-1:0] RESTART_BASE_RST  = 16'd25;
   localparam logic [CFG_BITS-1:0] GROWTH_FACTOR_RST = 16'd768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHRINK,
      ST_POW_LO,
      ST_POW_HI,
      ST_LIM_LO,
      ST_LIM_HI
   } lrl_state_type;

endpackage

// ----- rtl/core/luby_restart_limit.sv -----
// Luby restart limit: exponent search and fixed-point power on one shared multiplier.
// Steps: size the subsequence, shrink it to find the exponent, raise the factor to that
// power, multiply by the base and register the result. The 32x16 multiplier, used twice
// per product, sets the power and limit time. One item at a time: busy stays high until
// the result beat; rsp_valid pulses for one cycle and the receiver cannot stall.
// Synchronous reset loads base 25, factor 3.0 and returns to idle.
module luby_restart_limit
   import lrl_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wr_data,
   input  logic                    start,
   output logic                    busy,
   input  logic [INDEX_BITS-1:0]   req_restart_index,
   output logic                    rsp_valid,
   output logic [EXP_BITS-1:0]     rsp_exponent,
   output logic [LIMIT_BITS-1:0]   rsp_conflict_limit,
   output logic                    rsp_saturated
);

   localparam int SIZE_BITS = INDEX_BITS + 1;
   localparam logic [LIMIT_BITS-1:0] POW_ONE = LIMIT_BITS'(1) << FRAC_BITS;

   lrl_state_type state_ff, state_in;

   logic [CFG_BITS-1:0]   base_ff, factor_ff;
   logic [INDEX_BITS-1:0] x_ff, x_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic [EXP_BITS-1:0]   seq_ff, seq_in;
   logic [EXP_BITS-1:0]   cnt_ff, cnt_in;
   logic [LIMIT_BITS-1:0] power_ff, power_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                  huge_ff, huge_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EXP_BITS-1:0]   rsp_exp_ff, rsp_exp_in;
   logic [LIMIT_BITS-1:0] rsp_limit_ff, rsp_limit_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // shared multiplier and accumulate
   logic                  hi_half;
   logic [HALF_BITS-1:0]  mul_a;
   logic [CFG_BITS-1:0]   mul_b;
   logic [PROD_BITS-1:0]  prod;
   logic [ACC_BITS-1:0]   acc_sum;
   logic [ACC_BITS-1:0]   acc_shift;
   logic                  mul_ovf;

   // subsequence arithmetic
   logic [SIZE_BITS-1:0]  x_ext;
   logic [SIZE_BITS-1:0]  size_m1;
   logic [SIZE_BITS-1:0]  size_half;

   assign hi_half   = (state_ff == ST_POW_HI) || (state_ff == ST_LIM_HI);
   assign mul_a     = hi_half ? power_ff[LIMIT_BITS-1:HALF_BITS] : power_ff[HALF_BITS-1:0];
   assign mul_b     = ((state_ff == ST_POW_LO) || (state_ff == ST_POW_HI)) ? factor_ff
                                                                          : base_ff;
   assign prod      = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   assign acc_sum   = acc_ff + {prod, {HALF_BITS{1'b0}}};
   assign acc_shift = acc_sum >> FRAC_BITS;
   assign mul_ovf   = |acc_shift[ACC_BITS-1:LIMIT_BITS];

   assign x_ext     = {1'b0, x_ff};
   assign size_m1   = size_ff - SIZE_BITS'(1);
   assign size_half = size_m1 >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= RESTART_BASE_RST;
         factor_ff    <= GROWTH_FACTOR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RESTART_BASE:  base_ff   <= csr_wr_data;
               CSR_GROWTH_FACTOR: factor_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      size_ff      <= size_in;
      seq_ff       <= seq_in;
      cnt_ff       <= cnt_in;
      power_ff     <= power_in;
      acc_ff       <= acc_in;
      huge_ff      <= huge_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_limit_ff <= rsp_limit_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      size_in      = size_ff;
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      power_in     = power_ff;
      acc_in       = acc_ff;
      huge_in      = huge_ff;
      rsp_valid_in = 1'b0;
      rsp_exp_in   = rsp_exp_ff;
      rsp_limit_in = rsp_limit_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = req_restart_index;
               size_in  = SIZE_BITS'(1);
               seq_in   = '0;
               power_in = POW_ONE;
               huge_in  = 1'b0;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            // grow to the smallest 2^k-1 block that holds the index
            if (size_ff < x_ext + SIZE_BITS'(1)) begin
               size_in = {size_ff[SIZE_BITS-2:0], 1'b1};
               seq_in  = seq_ff + EXP_BITS'(1);
            end else begin
               state_in = ST_SHRINK;
            end
         end
         ST_SHRINK: begin
            if (size_m1 == x_ext) begin
               cnt_in   = seq_ff;
               state_in = ST_POW_LO;
            end else begin
               // index stays below twice the half size, so one subtract reduces it
               size_in = size_half;
               seq_in  = seq_ff - EXP_BITS'(1);
               if (x_ext >= size_half) begin
                  x_in = INDEX_BITS'(x_ext - size_half);
               end
            end
         end
         ST_POW_LO: begin
            if ((cnt_ff == '0) || huge_ff) begin
               acc_in   = ACC_BITS'(prod);
               state_in = ST_LIM_LO;
            end else begin
               acc_in   = ACC_BITS'(prod);
               state_in = ST_POW_HI;
            end
         end
         ST_POW_HI: begin
            power_in = acc_shift[LIMIT_BITS-1:0];
            huge_in  = mul_ovf;
            cnt_in   = cnt_ff - EXP_BITS'(1);
            state_in = ST_POW_LO;
         end
         ST_LIM_LO: begin
            // restart the low product now that the base is on the multiplier
            acc_in   = ACC_BITS'(prod);
            state_in = ST_LIM_HI;
         end
         ST_LIM_HI: begin
            rsp_valid_in = 1'b1;
            rsp_exp_in   = seq_ff;
            if (base_ff == '0) begin
               rsp_limit_in = '0;
               rsp_sat_in   = 1'b0;
            end else if (huge_ff || mul_ovf) begin
               rsp_limit_in = '1;
               rsp_sat_in   = 1'b1;
            end else begin
               rsp_limit_in = acc_shift[LIMIT_BITS-1:0];
               rsp_sat_in   = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_exponent       = rsp_exp_ff;
   assign rsp_conflict_limit = rsp_limit_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule
